// ===== rtl/core/ausd_pkg.sv =====
// ----------------------------------------------------------------------------
// ausd_pkg
// Shared types, codes and sample conversion functions of the AU stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ausd_pkg;

  localparam int unsigned MAX_CHANNELS_DEF = 255;
  localparam int unsigned OFIFO_DEPTH      = 4;
  localparam int unsigned BLOCK_W          = 10;
  localparam int unsigned QUO_W            = 32;
  localparam int unsigned HDR_LEN          = 24;

  localparam logic [2:0] KIND_SAMPLE = 3'd0;
  localparam logic [2:0] KIND_HEADER = 3'd1;
  localparam logic [2:0] KIND_END    = 3'd2;
  localparam logic [2:0] KIND_BADHDR = 3'd3;
  localparam logic [2:0] KIND_BADCH  = 3'd4;
  localparam logic [2:0] KIND_FLOAT  = 3'd5;

  localparam logic [31:0] ENC_MULAW  = 32'd1;
  localparam logic [31:0] ENC_LIN8   = 32'd2;
  localparam logic [31:0] ENC_LIN16  = 32'd3;
  localparam logic [31:0] ENC_LIN24  = 32'd4;
  localparam logic [31:0] ENC_LIN32  = 32'd5;
  localparam logic [31:0] ENC_FLOAT  = 32'd6;
  localparam logic [31:0] ENC_DOUBLE = 32'd7;
  localparam logic [31:0] ENC_ALAW   = 32'd27;

  localparam logic CFG_START_FRAME = 1'b0;
  localparam logic CFG_END_FRAME   = 1'b1;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] sample;
    logic [7:0]         channel;
    logic [31:0]        frame;
    logic [31:0]        sample_rate;
    logic [7:0]         channel_count;
    logic [31:0]        encoding;
    logic [31:0]        total_frames;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [31:0]        dividend;
    logic [BLOCK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] r;
    unique case (pos)
      2'd0:    r = 8'h2E;
      2'd1:    r = 8'h73;
      2'd2:    r = 8'h6E;
      default: r = 8'h64;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] sample_bytes(input logic [31:0] enc);
    logic [2:0] r;
    if (enc == ENC_MULAW || enc == ENC_LIN8 || enc == ENC_ALAW) r = 3'd1;
    else if (enc == ENC_LIN24) r = 3'd3;
    else if (enc == ENC_LIN32) r = 3'd4;
    else r = 3'd2;
    return r;
  endfunction

  function automatic logic [31:0] signed_mag(input logic neg, input logic [15:0] mag);
    logic [31:0] v;
    v = {mag, 16'h0000};
    return neg ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] mu_expand(input logic [7:0] b);
    logic [7:0]  v;
    logic [15:0] base;
    logic [15:0] mag;
    v    = ~b;
    base = {9'd0, v[3:0], 3'b000} + 16'h0084;
    mag  = (base << v[6:4]) - 16'h0084;
    return signed_mag(v[7], mag);
  endfunction

  function automatic logic [31:0] a_expand(input logic [7:0] b);
    logic [7:0]  v;
    logic [15:0] mag;
    v = b ^ 8'h55;
    if (v[6:4] == 3'd0) mag = {8'd0, v[3:0], 4'h0} + 16'h0008;
    else mag = ({8'd0, v[3:0], 4'h0} + 16'h0108) << (v[6:4] - 3'd1);
    return signed_mag(v[7], mag);
  endfunction

  function automatic logic [31:0] decode(input logic [31:0] enc, input logic [31:0] raw);
    logic [31:0] r;
    if (enc == ENC_MULAW) r = mu_expand(raw[7:0]);
    else if (enc == ENC_ALAW) r = a_expand(raw[7:0]);
    else if (enc == ENC_LIN8) r = {raw[7:0], 24'd0};
    else if (enc == ENC_LIN16) r = {raw[15:0], 16'd0};
    else if (enc == ENC_LIN24) r = {raw[23:0], 8'd0};
    else if (enc == ENC_LIN32) r = raw;
    else r = 32'd0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ausd_div.sv =====
// ----------------------------------------------------------------------------
// ausd_div
// Radix-2 restoring divider, one quotient bit per cycle, for the frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module ausd_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ausd_pkg::div_req_t req,
  output ausd_pkg::div_rsp_t      rsp
);

  localparam int unsigned BW    = ausd_pkg::BLOCK_W;
  localparam int unsigned QW    = ausd_pkg::QUO_W;
  localparam int unsigned CNT_W = $clog2(QW);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [BW-1:0]     rem_r;
  logic [BW-1:0]     dvs_r;
  logic [QW-1:0]     quo_r;

  logic [BW:0]       trial;
  logic              ge;
  logic [BW:0]       diff;

  assign trial = {rem_r, quo_r[QW-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[QW-2:0], ge};
      rem_r <= ge ? diff[BW-1:0] : trial[BW-1:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/ausd_ofifo.sv =====
// ----------------------------------------------------------------------------
// ausd_ofifo
// Small result queue taking up to two results per cycle, one out per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ausd_ofifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     push_n,
  input  wire ausd_pkg::out_t push_d0,
  input  wire ausd_pkg::out_t push_d1,
  output logic [$clog2(ausd_pkg::OFIFO_DEPTH):0] count,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ausd_pkg::out_t      out_data
);

  localparam int unsigned DEPTH = ausd_pkg::OFIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  ausd_pkg::out_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [PTR_W:0]   cnt_r;
  logic [PTR_W-1:0] wptr_p1;
  logic             pop;

  assign wptr_p1 = wptr_r + 1'b1;
  assign pop     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wptr_r] <= push_d0;
    if (push_n == 2'd2) mem_r[wptr_p1] <= push_d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + PTR_W'(push_n);
      if (pop) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W + 1)'(push_n) - (PTR_W + 1)'(pop);
    end
  end

  assign count     = cnt_r;
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rptr_r];

  ausd_ovf_a: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r + (PTR_W + 2)'(push_n) <= (PTR_W + 2)'(DEPTH) + (PTR_W + 2)'(pop))
    else $error("result queue overflow");

  ausd_push_a: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |=> out_valid)
    else $error("queue empty after push");

  ausd_cnt_a: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W + 1)'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/au_stream_sample_decoder.sv =====
// ----------------------------------------------------------------------------
// au_stream_sample_decoder
// AU stream parser: header check, offset skip, sample assembly and Q1.31 output.
// ----------------------------------------------------------------------------
// a byte is registered in the input stage, then its results go into the result queue;
// throughput: one byte per cycle while the queue has room for two results; the queue
// pops one result per cycle while out_stall is low; after an explicit data size,
// input stalls while the serial divider (one quotient bit per cycle) counts frames.
// reset: synchronous, clears the parser to the header phase, start_frame 1,
// end_frame 0, and empties the result queue
`default_nettype none

module au_stream_sample_decoder #(
  parameter int unsigned MAX_CHANNELS = ausd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ausd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ausd_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [31:0]    cfg_wdata
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_DRAIN  = 2'd3;
  localparam int unsigned BW       = ausd_pkg::BLOCK_W;
  localparam int unsigned CNT_W    = $clog2(ausd_pkg::OFIFO_DEPTH) + 1;

  // configuration
  logic [31:0] start_r, end_r;

  // input stage
  logic        s_vld_r;
  logic [7:0]  s_byte_r;
  logic        s_lb_r;

  // parser state
  logic [1:0]  phase_r, phase_nxt;
  logic [4:0]  hpos_r, hpos_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] enc_r, enc_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [7:0]  chan_r, chan_nxt;
  logic [23:0] part_r, part_nxt;
  logic [2:0]  bis_r, bis_nxt;
  logic [7:0]  chidx_r, chidx_nxt;
  logic [31:0] frame_r, frame_nxt;
  logic [31:0] bcnt_r, bcnt_nxt;
  logic [31:0] total_r;
  logic        pend_r, pend_nxt;

  ausd_pkg::div_req_t div_req;
  ausd_pkg::div_rsp_t div_rsp;

  logic [CNT_W-1:0] q_cnt;
  logic [1:0]       push_n;
  ausd_pkg::out_t   r0, r1;

  logic        proc_go, proc;
  logic        clr;
  logic [7:0]  b;
  logic        lb;
  logic        sized;
  logic [2:0]  bps;
  logic [31:0] chw;
  logic [7:0]  cc;
  logic [10:0] block;
  logic [31:0] raw;
  logic [31:0] first_f;
  logic        in_rng;
  logic [8:0]  ch_inc;
  logic        emit;

  assign proc_go  = (q_cnt <= CNT_W'(ausd_pkg::OFIFO_DEPTH - 2)) && !div_rsp.busy
                    && !div_rsp.done;
  assign proc     = s_vld_r && proc_go;
  assign in_stall = s_vld_r && !proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 32'd1;
      end_r   <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ausd_pkg::CFG_START_FRAME: start_r <= cfg_wdata;
        ausd_pkg::CFG_END_FRAME:   end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s_vld_r <= 1'b1;
    end else if (proc) begin
      s_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_byte_r <= in_data.stream_byte;
      s_lb_r   <= in_data.last_byte;
    end
  end

  assign b       = s_byte_r;
  assign lb      = s_lb_r;
  assign sized   = (size_r != 32'd0) && (size_r != 32'hFFFF_FFFF);
  assign bps     = ausd_pkg::sample_bytes(enc_r);
  assign chw     = {part_r, b};
  assign cc      = (part_r != 24'd0) ? 8'hFF : b;
  assign block   = 11'(b) * 11'(bps);
  assign raw     = {part_r, b};
  assign first_f = (start_r == 32'd0) ? 32'd0 : start_r - 32'd1;
  assign in_rng  = (frame_r >= first_f) && !((end_r != 32'd0) && (frame_r >= end_r))
                   && !(sized && (frame_r >= total_r));
  assign ch_inc  = {1'b0, chidx_r} + 9'd1;

  always_comb begin
    phase_nxt  = phase_r;
    hpos_nxt   = hpos_r;
    offset_nxt = offset_r;
    size_nxt   = size_r;
    enc_nxt    = enc_r;
    rate_nxt   = rate_r;
    chan_nxt   = chan_r;
    part_nxt   = part_r;
    bis_nxt    = bis_r;
    chidx_nxt  = chidx_r;
    frame_nxt  = frame_r;
    bcnt_nxt   = bcnt_r;
    pend_nxt   = pend_r;
    clr        = 1'b0;
    emit       = 1'b0;
    push_n     = 2'd0;
    r0         = '0;
    r1         = '0;
    div_req          = '0;
    div_req.dividend = size_r;
    div_req.divisor  = block[BW-1:0];

    if (div_rsp.done && pend_r) begin
      pend_nxt        = 1'b0;
      push_n          = 2'd1;
      r0.kind         = ausd_pkg::KIND_END;
      r0.total_frames = div_rsp.quo;
      r0.last         = 1'b1;
    end

    if (proc) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hpos_r < 5'd4 && b != ausd_pkg::magic_byte(hpos_r[1:0])) begin
            push_n  = 2'd1;
            r0.kind = ausd_pkg::KIND_BADHDR;
            r0.last = 1'b1;
            if (lb) clr = 1'b1;
            else phase_nxt = PH_DRAIN;
          end else if (hpos_r < 5'd23) begin
            priority if (hpos_r < 5'd4) begin
            end else if (hpos_r < 5'd8) begin
              offset_nxt = {offset_r[23:0], b};
            end else if (hpos_r < 5'd12) begin
              size_nxt = {size_r[23:0], b};
            end else if (hpos_r < 5'd16) begin
              enc_nxt = {enc_r[23:0], b};
            end else if (hpos_r < 5'd20) begin
              rate_nxt = {rate_r[23:0], b};
            end else begin
              part_nxt = {part_r[15:0], b};
            end
            hpos_nxt = hpos_r + 5'd1;
            if (lb) begin
              push_n  = 2'd1;
              r0.kind = ausd_pkg::KIND_BADHDR;
              r0.last = 1'b1;
              clr     = 1'b1;
            end
          end else begin
            part_nxt = '0;
            bcnt_nxt = 32'(ausd_pkg::HDR_LEN);
            r0.sample_rate   = rate_r;
            r0.channel_count = cc;
            r0.encoding      = enc_r;
            push_n           = 2'd1;
            if (chw == 32'd0 || chw > 32'(MAX_CHANNELS)) begin
              r0.kind = ausd_pkg::KIND_BADCH;
              r0.last = 1'b1;
              if (lb) clr = 1'b1;
              else phase_nxt = PH_DRAIN;
            end else if (enc_r == ausd_pkg::ENC_FLOAT || enc_r == ausd_pkg::ENC_DOUBLE) begin
              chan_nxt = b;
              r0.kind  = ausd_pkg::KIND_FLOAT;
              r0.last  = 1'b1;
              if (lb) clr = 1'b1;
              else phase_nxt = PH_DRAIN;
            end else begin
              chan_nxt = b;
              r0.kind  = ausd_pkg::KIND_HEADER;
              if (offset_r <= 32'(ausd_pkg::HDR_LEN)) begin
                phase_nxt = PH_DATA;
                bcnt_nxt  = 32'd0;
              end else begin
                phase_nxt = PH_SKIP;
              end
              div_req.start = sized;
              if (lb) begin
                clr = 1'b1;
                if (sized) begin
                  pend_nxt = 1'b1;
                end else begin
                  push_n          = 2'd2;
                  r1.kind         = ausd_pkg::KIND_END;
                  r1.total_frames = frame_r;
                  r1.last         = 1'b1;
                end
              end
            end
          end
        end
        PH_SKIP: begin
          bcnt_nxt = bcnt_r + 32'd1;
          if (bcnt_nxt >= offset_r) begin
            phase_nxt = PH_DATA;
            bcnt_nxt  = 32'd0;
          end
          if (lb) begin
            push_n          = 2'd1;
            r0.kind         = ausd_pkg::KIND_END;
            r0.total_frames = sized ? total_r : frame_r;
            r0.last         = 1'b1;
            clr             = 1'b1;
          end
        end
        PH_DATA: begin
          if (bcnt_r != 32'hFFFF_FFFF) bcnt_nxt = bcnt_r + 32'd1;
          if (bis_r + 3'd1 < bps) begin
            part_nxt = {part_r[15:0], b};
            bis_nxt  = bis_r + 3'd1;
          end else begin
            if (in_rng) begin
              emit       = 1'b1;
              r0.kind    = ausd_pkg::KIND_SAMPLE;
              r0.sample  = ausd_pkg::decode(enc_r, raw);
              r0.channel = chidx_r;
              r0.frame   = frame_r;
            end
            part_nxt = '0;
            bis_nxt  = 3'd0;
            if (ch_inc >= {1'b0, chan_r}) begin
              chidx_nxt = 8'd0;
              if (frame_r != 32'hFFFF_FFFF) frame_nxt = frame_r + 32'd1;
            end else begin
              chidx_nxt = ch_inc[7:0];
            end
          end
          push_n = emit ? 2'd1 : 2'd0;
          if (lb || (sized && bcnt_nxt == size_r)) begin
            if (emit) begin
              push_n          = 2'd2;
              r1.kind         = ausd_pkg::KIND_END;
              r1.total_frames = sized ? total_r : frame_nxt;
              r1.last         = 1'b1;
            end else begin
              push_n          = 2'd1;
              r0.kind         = ausd_pkg::KIND_END;
              r0.total_frames = sized ? total_r : frame_nxt;
              r0.last         = 1'b1;
            end
            if (lb) clr = 1'b1;
            else phase_nxt = PH_DRAIN;
          end
        end
        PH_DRAIN: begin
          if (lb) clr = 1'b1;
        end
        default: ;
      endcase
    end

    if (clr) begin
      phase_nxt  = PH_HEADER;
      hpos_nxt   = '0;
      offset_nxt = '0;
      size_nxt   = '0;
      enc_nxt    = '0;
      rate_nxt   = '0;
      chan_nxt   = '0;
      part_nxt   = '0;
      bis_nxt    = '0;
      chidx_nxt  = '0;
      frame_nxt  = '0;
      bcnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      hpos_r   <= '0;
      offset_r <= '0;
      size_r   <= '0;
      enc_r    <= '0;
      rate_r   <= '0;
      chan_r   <= '0;
      part_r   <= '0;
      bis_r    <= '0;
      chidx_r  <= '0;
      frame_r  <= '0;
      bcnt_r   <= '0;
      pend_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hpos_r   <= hpos_nxt;
      offset_r <= offset_nxt;
      size_r   <= size_nxt;
      enc_r    <= enc_nxt;
      rate_r   <= rate_nxt;
      chan_r   <= chan_nxt;
      part_r   <= part_nxt;
      bis_r    <= bis_nxt;
      chidx_r  <= chidx_nxt;
      frame_r  <= frame_nxt;
      bcnt_r   <= bcnt_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_rsp.done) total_r <= div_rsp.quo;
  end

  ausd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ausd_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_d0   (r0),
    .push_d1   (r1),
    .count     (q_cnt),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  ausd_divrun_a: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> div_rsp.busy)
    else $error("frame count divider did not start");

  ausd_pend_a: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (div_rsp.busy || div_rsp.done))
    else $error("pending end beat without divider activity");

  ausd_bis_a: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bis_r < bps))
    else $error("byte position past sample width");

  ausd_chidx_a: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (chidx_r < chan_r))
    else $error("channel index past channel count");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Feeds AU byte streams (good headers with random content, broken magic,
// cut headers, bad channel counts, float encodings, offset skips, sized and
// open-ended data) into the decoder under random source and sink idling, and
// checks every result field against a behavioral decoder kept in the bench.
// ---------------------------------------------------------------------------

module testbench;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BEATS = 90;
  localparam int SETTLE      = 64;
  localparam int PHASES      = 8;
  localparam logic [31:0] SND_TAG = 32'h2E736E64;
  localparam ausd_pkg::out_t NO_RESULT = '0;

  typedef enum logic [1:0] {P_HEADER, P_SKIP, P_DATA, P_DRAIN} parse_t;

  typedef struct packed {
    ausd_pkg::in_t  beat;
    logic           typed;
    ausd_pkg::out_t want;
  } row_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  ausd_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  ausd_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic           cfg_index = ausd_pkg::CFG_START_FRAME;
  logic [31:0]    cfg_wdata = '0;

  // decoder state mirrored in the bench
  parse_t      parse_ph;
  logic [4:0]  hdr_pos;
  logic [31:0] hdr_offset, hdr_size, hdr_enc, hdr_rate;
  logic [7:0]  ch_count;
  logic [23:0] acc;
  logic [2:0]  acc_n;
  logic [7:0]  ch_at;
  logic [31:0] frame_at, data_count;
  logic [31:0] first_frame_reg, last_frame_reg;

  ausd_pkg::out_t step_results [$];
  ausd_pkg::out_t due_events [$];

  int mismatches = 0;
  int results_taken = 0;
  int samples_taken = 0;
  int beats_sent = 0;
  int streams_sent = 0;
  int src_mode = 0;
  int sink_mode = 0;
  int sink_hold = 0;
  int hold_off = 0;
  int unsigned cycle_count = 0;

  row_t directed_rows [25] = '{
    '{'{8'hFF, 1'b1}, 1'b1,
      '{ausd_pkg::KIND_BADHDR, 32'd0, 8'd0, 32'd0, 32'd0, 8'd0, 32'd0, 32'd0, 1'b1}},
    '{'{8'h2E, 1'b0}, 1'b0, NO_RESULT}, '{'{8'h73, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h6E, 1'b0}, 1'b0, NO_RESULT}, '{'{8'h64, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT}, '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT}, '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT}, '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT}, '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT}, '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT}, '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT}, '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT}, '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT}, '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1}, 1'b1,
      '{ausd_pkg::KIND_BADCH, 32'd0, 8'd0, 32'd0, 32'hFFFFFFFF, 8'hFF,
        32'hFFFFFFFF, 32'd0, 1'b1}}
  };

  au_stream_sample_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               due_events.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic int idle_draw(input int mode);
    case (mode)
      0:       return 0;
      1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic void stream_restart();
    parse_ph   = P_HEADER;
    hdr_pos    = '0;
    hdr_offset = '0;
    hdr_size   = '0;
    hdr_enc    = '0;
    hdr_rate   = '0;
    ch_count   = '0;
    acc        = '0;
    acc_n      = '0;
    ch_at      = '0;
    frame_at   = '0;
    data_count = '0;
  endfunction

  function automatic int bytes_per_sample(input logic [31:0] enc);
    case (enc)
      ausd_pkg::ENC_MULAW, ausd_pkg::ENC_LIN8, ausd_pkg::ENC_ALAW: return 1;
      ausd_pkg::ENC_LIN24:                                         return 3;
      ausd_pkg::ENC_LIN32:                                         return 4;
      default:                                                     return 2;
    endcase
  endfunction

  function automatic bit has_size();
    return hdr_size != 32'd0 && hdr_size != 32'hFFFFFFFF;
  endfunction

  function automatic logic [31:0] sized_frames();
    logic [31:0] block;
    block = 32'(ch_count) * 32'(bytes_per_sample(hdr_enc));
    return (block != 0) ? hdr_size / block : 32'd0;
  endfunction

  function automatic logic [31:0] frames_total();
    return has_size() ? sized_frames() : frame_at;
  endfunction

  function automatic logic [31:0] q31_of(input logic neg, input logic [31:0] mag);
    return neg ? -(mag << 16) : (mag << 16);
  endfunction

  function automatic logic [31:0] ulaw_q31(input logic [7:0] code);
    logic [7:0]  v;
    logic [31:0] seg, mant;
    v    = ~code;
    seg  = 32'(v[6:4]);
    mant = 32'(v[3:0]);
    return q31_of(v[7], (((mant << 3) + 32'h84) << seg) - 32'h84);
  endfunction

  function automatic logic [31:0] alaw_q31(input logic [7:0] code);
    logic [7:0]  v;
    logic [31:0] seg, mant, mag;
    v    = code ^ 8'h55;
    seg  = 32'(v[6:4]);
    mant = 32'(v[3:0]);
    if (seg == 0) mag = (mant << 4) + 32'd8;
    else mag = ((mant << 4) + 32'h108) << (seg - 1);
    return q31_of(v[7], mag);
  endfunction

  function automatic logic [31:0] to_q31(input logic [31:0] raw);
    case (hdr_enc)
      ausd_pkg::ENC_MULAW: return ulaw_q31(raw[7:0]);
      ausd_pkg::ENC_ALAW:  return alaw_q31(raw[7:0]);
      ausd_pkg::ENC_LIN8:  return {raw[7:0], 24'd0};
      ausd_pkg::ENC_LIN16: return {raw[15:0], 16'd0};
      ausd_pkg::ENC_LIN24: return {raw[23:0], 8'd0};
      ausd_pkg::ENC_LIN32: return raw;
      default:             return 32'd0;
    endcase
  endfunction

  function automatic bit wanted(input logic [31:0] f);
    logic [31:0] lo;
    lo = (first_frame_reg == 0) ? 32'd0 : first_frame_reg - 1;
    if (f < lo) return 1'b0;
    if (last_frame_reg != 0 && f >= last_frame_reg) return 1'b0;
    if (has_size() && f >= sized_frames()) return 1'b0;
    return 1'b1;
  endfunction

  function automatic ausd_pkg::out_t blank_result(input logic [2:0] k, input logic lst);
    ausd_pkg::out_t r;
    r      = '0;
    r.kind = k;
    r.last = lst;
    return r;
  endfunction

  function automatic void add_result(input ausd_pkg::out_t r);
    step_results = {step_results, r};
  endfunction

  function automatic void stream_stop(input logic lb);
    if (lb) stream_restart();
    else parse_ph = P_DRAIN;
  endfunction

  function automatic void push_end();
    ausd_pkg::out_t r;
    r = blank_result(ausd_pkg::KIND_END, 1'b1);
    r.total_frames = frames_total();
    add_result(r);
  endfunction

  // one accepted byte: advance the mirrored parser and collect its results
  function automatic void au_decode_beat(input ausd_pkg::in_t x);
    logic [7:0]     b;
    logic           lb;
    logic [31:0]    chw, raw;
    ausd_pkg::out_t r;
    b  = x.stream_byte;
    lb = x.last_byte;
    step_results.delete();
    case (parse_ph)
      P_HEADER: begin
        if (hdr_pos < 4) begin
          if (b != SND_TAG[8*(3-int'(hdr_pos)) +: 8]) begin
            add_result(blank_result(ausd_pkg::KIND_BADHDR, 1'b1));
            stream_stop(lb);
            return;
          end
        end else if (hdr_pos < 8) hdr_offset = {hdr_offset[23:0], b};
        else if (hdr_pos < 12) hdr_size = {hdr_size[23:0], b};
        else if (hdr_pos < 16) hdr_enc = {hdr_enc[23:0], b};
        else if (hdr_pos < 20) hdr_rate = {hdr_rate[23:0], b};
        else if (hdr_pos < 23) acc = {acc[15:0], b};
        if (hdr_pos < 23) begin
          hdr_pos = hdr_pos + 1;
          if (lb) begin
            add_result(blank_result(ausd_pkg::KIND_BADHDR, 1'b1));
            stream_restart();
          end
          return;
        end
        chw = {acc, b};
        acc = '0;
        data_count = 32'd24;
        r = blank_result(ausd_pkg::KIND_HEADER, 1'b0);
        r.sample_rate   = hdr_rate;
        r.channel_count = (chw > 255) ? 8'hFF : chw[7:0];
        r.encoding      = hdr_enc;
        if (chw == 0 || chw > ausd_pkg::MAX_CHANNELS_DEF) begin
          r.kind = ausd_pkg::KIND_BADCH;
          r.last = 1'b1;
          add_result(r);
          stream_stop(lb);
          return;
        end
        ch_count = chw[7:0];
        if (hdr_enc == ausd_pkg::ENC_FLOAT || hdr_enc == ausd_pkg::ENC_DOUBLE) begin
          r.kind = ausd_pkg::KIND_FLOAT;
          r.last = 1'b1;
          add_result(r);
          stream_stop(lb);
          return;
        end
        add_result(r);
        if (hdr_offset <= 24) begin
          parse_ph   = P_DATA;
          data_count = '0;
        end else parse_ph = P_SKIP;
        if (lb) begin
          push_end();
          stream_restart();
        end
      end
      P_SKIP: begin
        data_count = data_count + 1;
        if (data_count >= hdr_offset) begin
          parse_ph   = P_DATA;
          data_count = '0;
        end
        if (lb) begin
          push_end();
          stream_restart();
        end
      end
      P_DATA: begin
        if (data_count != 32'hFFFFFFFF) data_count = data_count + 1;
        if (acc_n + 1 < bytes_per_sample(hdr_enc)) begin
          acc   = {acc[15:0], b};
          acc_n = acc_n + 1;
        end else begin
          raw = {acc, b};
          if (wanted(frame_at)) begin
            r = blank_result(ausd_pkg::KIND_SAMPLE, 1'b0);
            r.sample  = to_q31(raw);
            r.channel = ch_at;
            r.frame   = frame_at;
            add_result(r);
          end
          acc   = '0;
          acc_n = '0;
          ch_at = ch_at + 1;
          if (ch_at >= ch_count) begin
            ch_at = '0;
            if (frame_at != 32'hFFFFFFFF) frame_at = frame_at + 1;
          end
        end
        if (lb || (has_size() && data_count == hdr_size)) begin
          push_end();
          stream_stop(lb);
        end
      end
      default: if (lb) stream_restart();
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", msg);
  endtask

  task automatic weigh(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %0h want %0h", results_taken, name, got,
                              want));
  endtask

  always @(posedge clk) begin
    ausd_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_events.size() == 0) begin
        flag_mismatch($sformatf("result %0d of kind %0d with nothing due", results_taken,
                                out_data.kind));
      end else begin
        want = due_events.pop_front();
        weigh("kind", 32'(out_data.kind), 32'(want.kind));
        weigh("sample", out_data.sample, want.sample);
        weigh("channel", 32'(out_data.channel), 32'(want.channel));
        weigh("frame", out_data.frame, want.frame);
        weigh("sample_rate", out_data.sample_rate, want.sample_rate);
        weigh("channel_count", 32'(out_data.channel_count), 32'(want.channel_count));
        weigh("encoding", out_data.encoding, want.encoding);
        weigh("total_frames", out_data.total_frames, want.total_frames);
        weigh("last", 32'(out_data.last), 32'(want.last));
      end
      results_taken++;
      if (out_data.kind == ausd_pkg::KIND_SAMPLE) samples_taken++;
      sink_hold = idle_draw(sink_mode);
    end
  end

  // sink side: a long hold-off first, then the per-beat waits
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off = hold_off - 1;
    end else if (sink_hold > 0) begin
      out_stall <= 1'b1;
      sink_hold = sink_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic offer_beat(input ausd_pkg::in_t beat, input logic typed,
                            input ausd_pkg::out_t typed_want);
    int gap;
    gap = idle_draw(src_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    au_decode_beat(beat);
    if (typed) begin
      step_results.delete();
      add_result(typed_want);
    end
    foreach (step_results[k]) due_events = {due_events, step_results[k]};
  endtask

  task automatic set_register(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ausd_pkg::CFG_START_FRAME) first_frame_reg = val;
    else last_frame_reg = val;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_stream(input bit wide);
    logic [7:0]    body [$];
    logic [31:0]   words [5];
    logic [31:0]   off, sz, enc, rate, chw;
    int            pick, cut, skip, n, r, i, k;
    ausd_pkg::in_t beat;
    src_mode  = $urandom_range(0, 2);
    sink_mode = $urandom_range(0, 2);
    pick = wide ? 99 : $urandom_range(0, 99);
    for (i = 3; i >= 0; i--) body = {body, SND_TAG[8*i +: 8]};
    if (pick < 6) begin
      // broken tag, then some trailing junk
      cut = $urandom_range(0, 3);
      while (body.size() > cut) body.delete(body.size() - 1);
      body = {body, SND_TAG[8*(3-cut) +: 8] ^ 8'($urandom_range(1, 255))};
      n = $urandom_range(0, 4);
      repeat (n) body = {body, 8'($urandom)};
    end else begin
      r = $urandom_range(0, 19);
      if (r < 3) enc = ausd_pkg::ENC_MULAW;
      else if (r < 5) enc = ausd_pkg::ENC_LIN8;
      else if (r < 8) enc = ausd_pkg::ENC_LIN16;
      else if (r < 10) enc = ausd_pkg::ENC_LIN24;
      else if (r < 12) enc = ausd_pkg::ENC_LIN32;
      else if (r < 15) enc = ausd_pkg::ENC_ALAW;
      else if (r == 15) enc = ausd_pkg::ENC_FLOAT;
      else if (r == 16) enc = ausd_pkg::ENC_DOUBLE;
      else enc = $urandom_range(0, 1) ? 32'($urandom) : 32'd0;
      r = $urandom_range(0, 19);
      if (r == 0) chw = 32'd0;
      else if (r == 1) chw = 32'($urandom) | 32'h100;
      else if (r == 2) chw = 32'd255;
      else if (r == 3) chw = $urandom_range(5, 40);
      else chw = $urandom_range(1, 4);
      r = $urandom_range(0, 19);
      if (r < 12) off = 32'd24;
      else if (r < 15) off = $urandom_range(0, 23);
      else if (r < 19) off = $urandom_range(25, 40);
      else off = 32'($urandom) | 32'h1000;
      r = $urandom_range(0, 19);
      if (r < 7) sz = 32'd0;
      else if (r < 11) sz = 32'hFFFFFFFF;
      else sz = $urandom_range(1, 48);
      rate = $urandom;
      n = $urandom_range(0, 36);
      if (wide) begin
        // every channel index of a full frame
        chw = 32'd255;
        off = 32'd24;
        sz  = 32'd0;
        r   = $urandom_range(0, 2);
        enc = (r == 0) ? ausd_pkg::ENC_MULAW : (r == 1) ? ausd_pkg::ENC_ALAW
                                                         : ausd_pkg::ENC_LIN8;
        n   = $urandom_range(255, 275);
      end
      words = '{off, sz, enc, rate, chw};
      for (k = 0; k < 5; k++)
        for (i = 3; i >= 0; i--) body = {body, words[k][8*i +: 8]};
      if (pick < 12) begin
        cut = $urandom_range(1, 23);
        while (body.size() > cut) body.delete(body.size() - 1);
      end else begin
        if (off > 24 && off <= 40) skip = off - 24;
        else if (off > 40) skip = $urandom_range(0, 8);
        else skip = 0;
        repeat (skip + n) body = {body, 8'($urandom)};
      end
    end
    for (i = 0; i < body.size(); i++) begin
      beat.stream_byte = body[i];
      beat.last_byte   = (i == body.size() - 1);
      offer_beat(beat, 1'b0, NO_RESULT);
    end
    streams_sent++;
  endtask

  initial begin
    int          p, mark;
    logic [31:0] lo_set, hi_set;
    first_frame_reg = 32'd1;
    last_frame_reg  = 32'd0;
    stream_restart();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        case (p)
          1: begin lo_set = 32'd0;          hi_set = 32'd0;          end
          2: begin lo_set = 32'd2;          hi_set = 32'd4;          end
          3: begin lo_set = 32'hFFFFFFFF;   hi_set = 32'hFFFFFFFF;   end
          4: begin lo_set = 32'd1;          hi_set = 32'hFFFFFFFF;   end
          5: begin lo_set = $urandom_range(0, 4); hi_set = $urandom_range(0, 6); end
          6: begin lo_set = 32'd3;          hi_set = 32'd0;          end
          default: begin lo_set = 32'd1;    hi_set = 32'd1;          end
        endcase
        if (p == 2) hold_off = 300;
        set_register(ausd_pkg::CFG_START_FRAME, lo_set);
        set_register(ausd_pkg::CFG_END_FRAME, hi_set);
      end
      mark = beats_sent;
      if (p == 1) random_stream(1'b1);
      while (beats_sent - mark < PHASE_BEATS) random_stream(1'b0);
    end

    drain_results();
    $display("covered %0d streams in %0d input beats over %0d frame range settings",
             streams_sent, beats_sent, PHASES);
    $display("checked %0d results, %0d of them samples, %0d mismatches", results_taken,
             samples_taken, mismatches);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ausd_pkg.sv
rtl/core/ausd_div.sv
rtl/core/ausd_ofifo.sv
rtl/core/au_stream_sample_decoder.sv
bench/testbench.sv
